@@ rtl/ecc_pkg.sv @@
// shared widths, codes and control/status types for the elevator call controller
`timescale 1ns / 1ps

package ecc_pkg;

    localparam int FLOOR_W        = 5;
    localparam int CFG_W          = 5;
    localparam int FUNC_W         = 2;
    localparam int CMD_W          = 2;
    localparam int SCAN_W         = FLOOR_W + 1;
    localparam int DEF_MAX_FLOORS = 16;

    localparam logic [CFG_W-1:0]   CFG_RESET   = 5'd9;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 5'd1;

    // event kinds
    localparam logic [FUNC_W-1:0] FUNC_CALL   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ARRIVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DONE   = 2'd2;

    // drive commands
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    typedef struct packed {
        logic exec;        // handle accepted event directly, without a search
        logic start_scan;  // load scan pointer at current floor
        logic step;        // advance scan pointer one floor
        logic flip;        // restart scan in the other direction
        logic take;        // scan pointer hit a pending call
        logic none;        // nothing pending anywhere
    } t_ctrl_cmd;

    typedef struct packed {
        logic travel;
        logic hit;
        logic scan_end;
        logic out_busy;
    } t_dp_status;

endpackage

@@ rtl/ecc_ctrl.sv @@
// sequencer: accepts events and walks the target search over the floors
`timescale 1ns / 1ps

module ecc_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [ecc_pkg::FUNC_W-1:0] i_func,
    output logic                       o_in_stall,
    input  ecc_pkg::t_dp_status        i_status,
    output ecc_pkg::t_ctrl_cmd         o_cmd
);
    import ecc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_FWD  = 3'b010,
        ST_REV  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_stall = (r_state != ST_IDLE) || i_status.out_busy;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_DONE && i_status.travel) begin
                        o_cmd.start_scan = 1'b1;
                        n_state          = ST_FWD;
                    end else begin
                        o_cmd.exec = 1'b1;
                    end
                end
            end
            ST_FWD: begin
                if (i_status.hit) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_IDLE;
                end else if (i_status.scan_end) begin
                    o_cmd.flip = 1'b1;
                    n_state    = ST_REV;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_REV: begin
                if (i_status.hit) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_IDLE;
                end else if (i_status.scan_end) begin
                    o_cmd.none = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/ecc_datapath.sv @@
// call bitmap, car state, scan pointer and result register
`timescale 1ns / 1ps

module ecc_datapath #(
    parameter int MAX_FLOORS = ecc_pkg::DEF_MAX_FLOORS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ecc_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [ecc_pkg::FUNC_W-1:0]  i_func,
    input  logic [ecc_pkg::FLOOR_W-1:0] i_floor,
    input  ecc_pkg::t_ctrl_cmd          i_cmd,
    output ecc_pkg::t_dp_status         o_status,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [ecc_pkg::CMD_W-1:0]   o_command,
    output logic                        o_direction,
    output logic                        o_already_called,
    output logic                        o_no_pending,
    output logic [ecc_pkg::FLOOR_W-1:0] o_floor_now
);
    import ecc_pkg::*;

    logic [CFG_W-1:0]      r_cfg;
    logic [MAX_FLOORS-1:0] r_pending, n_pending;
    logic                  r_travel, n_travel;
    logic [FLOOR_W-1:0]    r_floor, n_floor;
    logic [FLOOR_W-1:0]    r_target, n_target;
    logic                  r_dir, n_dir;
    logic [SCAN_W-1:0]     r_scan, n_scan;
    logic                  r_scan_dn, n_scan_dn;

    logic                  r_out_valid, n_out_valid;
    logic [CMD_W-1:0]      r_command, n_command;
    logic                  r_direction, n_direction;
    logic                  r_already, n_already;
    logic                  r_no_pend, n_no_pend;
    logic [FLOOR_W-1:0]    r_floor_now, n_floor_now;

    logic [FLOOR_W-1:0]    served;
    logic                  take_en;
    logic [FLOOR_W-1:0]    take_fl;
    logic                  wr;

    assign served = (32'(r_cfg) > MAX_FLOORS) ? FLOOR_W'(MAX_FLOORS) : r_cfg;

    function automatic logic [MAX_FLOORS-1:0] floor_mask(input logic [FLOOR_W-1:0] f);
        logic [MAX_FLOORS-1:0] m;
        for (int k = 0; k < MAX_FLOORS; k++) begin
            m[k] = (32'(f) == k + 1);
        end
        return m;
    endfunction

    function automatic logic in_range(input logic [FLOOR_W-1:0] f,
                                      input logic [FLOOR_W-1:0] n);
        return (f != '0) && (f <= n);
    endfunction

    function automatic logic is_pending(input logic [FLOOR_W-1:0]    f,
                                        input logic [FLOOR_W-1:0]    n,
                                        input logic [MAX_FLOORS-1:0] p);
        return in_range(f, n) && (|(p & floor_mask(f)));
    endfunction

    // scan pointer stays within 1..31 whenever it can hit, so its low bits are the floor
    always_comb begin
        o_status.travel   = r_travel;
        o_status.hit      = (r_scan[SCAN_W-1] == 1'b0)
                          && is_pending(r_scan[FLOOR_W-1:0], served, r_pending);
        o_status.scan_end = r_scan_dn ? (r_scan == '0) : (r_scan > {1'b0, served});
        o_status.out_busy = r_out_valid && i_out_stall;
    end

    always_comb begin
        n_pending   = r_pending;
        n_travel    = r_travel;
        n_floor     = r_floor;
        n_target    = r_target;
        n_dir       = r_dir;
        n_scan      = r_scan;
        n_scan_dn   = r_scan_dn;
        n_out_valid = r_out_valid && i_out_stall;
        n_command   = r_command;
        n_direction = r_direction;
        n_already   = r_already;
        n_no_pend   = r_no_pend;
        n_floor_now = r_floor_now;
        take_en     = 1'b0;
        take_fl     = i_floor;
        wr          = 1'b0;

        if (i_cmd.exec) begin
            wr        = 1'b1;
            n_command = CMD_NONE;
            n_already = 1'b0;
            n_no_pend = 1'b0;
            case (i_func)
                FUNC_CALL: begin
                    if (in_range(i_floor, served)) begin
                        if (is_pending(i_floor, served, r_pending)) begin
                            n_already = 1'b1;
                        end else begin
                            n_pending = r_pending | floor_mask(i_floor);
                            take_en   = !r_travel;
                        end
                    end
                end
                FUNC_ARRIVE: begin
                    if (r_travel && in_range(i_floor, served)) begin
                        n_floor = i_floor;
                        if (i_floor == r_target) begin
                            n_pending = r_pending & ~floor_mask(i_floor);
                            n_command = CMD_STOP;
                        end else begin
                            n_command = CMD_MOVE;
                        end
                    end
                end
                default: begin
                    // done while idle, or unused kind: no effect
                end
            endcase
        end

        if (i_cmd.start_scan) begin
            n_scan    = {1'b0, r_floor};
            n_scan_dn = r_dir;
        end

        if (i_cmd.step) begin
            n_scan = r_scan_dn ? (r_scan - SCAN_W'(1)) : (r_scan + SCAN_W'(1));
        end

        if (i_cmd.flip) begin
            n_scan    = {1'b0, r_floor};
            n_scan_dn = ~r_scan_dn;
        end

        if (i_cmd.take) begin
            wr        = 1'b1;
            n_already = 1'b0;
            n_no_pend = 1'b0;
            take_en   = 1'b1;
            take_fl   = r_scan[FLOOR_W-1:0];
        end

        if (i_cmd.none) begin
            wr        = 1'b1;
            n_travel  = 1'b0;
            n_command = CMD_NONE;
            n_already = 1'b0;
            n_no_pend = 1'b1;
        end

        // new target: set direction, then move or stop right here
        if (take_en) begin
            n_target = take_fl;
            n_travel = 1'b1;
            if (r_floor < take_fl) begin
                n_dir = DIR_UP;
            end else if (r_floor > take_fl) begin
                n_dir = DIR_DOWN;
            end
            if (r_floor == take_fl) begin
                n_pending = n_pending & ~floor_mask(r_floor);
                n_command = CMD_STOP;
            end else begin
                n_command = CMD_MOVE;
            end
        end

        if (wr) begin
            n_out_valid = 1'b1;
            n_direction = n_dir;
            n_floor_now = n_floor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_pending   <= '0;
            r_travel    <= 1'b0;
            r_floor     <= FLOOR_RESET;
            r_target    <= FLOOR_RESET;
            r_dir       <= DIR_UP;
            r_scan      <= '0;
            r_scan_dn   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            r_pending   <= n_pending;
            r_travel    <= n_travel;
            r_floor     <= n_floor;
            r_target    <= n_target;
            r_dir       <= n_dir;
            r_scan      <= n_scan;
            r_scan_dn   <= n_scan_dn;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_command   <= n_command;
        r_direction <= n_direction;
        r_already   <= n_already;
        r_no_pend   <= n_no_pend;
        r_floor_now <= n_floor_now;
    end

    assign o_out_valid      = r_out_valid;
    assign o_command        = r_command;
    assign o_direction      = r_direction;
    assign o_already_called = r_already;
    assign o_no_pending     = r_no_pend;
    assign o_floor_now      = r_floor_now;

endmodule

@@ rtl/elevator_call_controller.sv @@
// top level of the elevator call controller: sequencer plus datapath
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one event per transaction:
//   i_func selects a floor call, an arrival or a stop-completed event, i_floor
//   gives the floor. Output channel (o_out_valid / i_out_stall) returns exactly
//   one result per event: drive command, direction, flags and current floor.
//   i_cfg_we / i_cfg_data write the number of served floors (reset 9).
// Event handling:
//   calls, arrivals and ignored events finish in the accept cycle; the result
//   is registered and shows in the next cycle. A stop-completed event while
//   travelling runs the target search, one floor per cycle over the forward
//   and then the reverse direction, using the single scan pointer in the
//   datapath. One event is in work at a time.
// Reset:
//   no calls pending, car at floor 1, idle, direction up, output empty.
// Stall:
//   a result held by i_out_stall stays in the output register; a new event is
//   taken in the cycle that register empties.
//
module elevator_call_controller #(
    parameter int MAX_FLOORS = ecc_pkg::DEF_MAX_FLOORS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ecc_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ecc_pkg::FUNC_W-1:0]  i_func,
    input  logic [ecc_pkg::FLOOR_W-1:0] i_floor,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ecc_pkg::CMD_W-1:0]   o_command,
    output logic                        o_direction,
    output logic                        o_already_called,
    output logic                        o_no_pending,
    output logic [ecc_pkg::FLOOR_W-1:0] o_floor_now
);
    import ecc_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    ecc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ecc_datapath #(
        .MAX_FLOORS (MAX_FLOORS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_func           (i_func),
        .i_floor          (i_floor),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_command        (o_command),
        .o_direction      (o_direction),
        .o_already_called (o_already_called),
        .o_no_pending     (o_no_pending),
        .o_floor_now      (o_floor_now)
    );

endmodule

@@ rtl/ecc_checker.sv @@
// port-level checks for the elevator call controller, bound to the top level
`timescale 1ns / 1ps

module ecc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_stall,
    input logic [ecc_pkg::CMD_W-1:0]   i_command,
    input logic                        i_already_called,
    input logic                        i_no_pending,
    input logic [ecc_pkg::FLOOR_W-1:0] i_floor_now
);
    import ecc_pkg::*;

    // held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_command)
            && $stable(i_floor_now))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_none_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_no_pending |-> i_command == CMD_NONE && !i_already_called)
        else $error("no-pending result carries a command");

    a_repeat_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_already_called |-> i_command == CMD_NONE)
        else $error("repeated call issued a command");

    a_floor_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_floor_now != '0)
        else $error("current floor reported as zero");

endmodule

bind elevator_call_controller ecc_checker u_ecc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .i_command        (o_command),
    .i_already_called (o_already_called),
    .i_no_pending     (o_no_pending),
    .i_floor_now      (o_floor_now)
);

@@ test/tb_elevator_call_controller.sv @@
// self-checking testbench for the elevator call controller: directed and random events
`timescale 1ns / 1ps
module tb_elevator_call_controller;
    import ecc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 2 * DEF_MAX_FLOORS + 8;
    localparam int PHASE_EVENTS  = 80;
    localparam int NUM_PHASES    = 8;

    typedef enum logic {CAR_IDLE, CAR_MOVING} t_car_mode;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic               dir;
        logic               already;
        logic               none;
        logic [FLOOR_W-1:0] floor_now;
    } t_car_result;

    class call_scoreboard;
        logic [DEF_MAX_FLOORS-1:0] call_map;
        logic [FLOOR_W-1:0]        car_floor;
        logic [FLOOR_W-1:0]        goal_floor;
        logic                      heading;
        t_car_mode                 cmode;
        logic [CFG_W-1:0]          floors_cfg;
        t_car_result               expected_q[$];
        int                        errors;
        int                        checked;

        function new();
            call_map   = '0;
            car_floor  = FLOOR_RESET;
            goal_floor = FLOOR_RESET;
            heading    = DIR_UP;
            cmode      = CAR_IDLE;
            floors_cfg = CFG_RESET;
            errors     = 0;
            checked    = 0;
        endfunction

        function int served();
            return (floors_cfg > DEF_MAX_FLOORS) ? DEF_MAX_FLOORS : int'(floors_cfg);
        endfunction

        function bit is_called(int f);
            if (f < 1 || f > served())
                return 1'b0;
            return call_map[f-1];
        endfunction

        function void clear_call(int f);
            if (f >= 1 && f <= DEF_MAX_FLOORS)
                call_map[f-1] = 1'b0;
        endfunction

        // set a new goal and decide between moving and stopping right here
        function logic [CMD_W-1:0] head_for(int t);
            goal_floor = t[FLOOR_W-1:0];
            if (car_floor < goal_floor)
                heading = DIR_UP;
            else if (car_floor > goal_floor)
                heading = DIR_DOWN;
            cmode = CAR_MOVING;
            if (car_floor == goal_floor) begin
                clear_call(int'(car_floor));
                return CMD_STOP;
            end
            return CMD_MOVE;
        endfunction

        function bit scan_calls(bit up, output int found);
            int f;
            found = 0;
            if (up) begin
                for (f = int'(car_floor); f <= served(); f++) begin
                    if (is_called(f)) begin
                        found = f;
                        return 1'b1;
                    end
                end
            end else begin
                for (f = int'(car_floor); f >= 1; f--) begin
                    if (is_called(f)) begin
                        found = f;
                        return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void note_event(logic [FUNC_W-1:0] f, logic [FLOOR_W-1:0] fl);
            t_car_result r;
            int          fi;
            int          t;
            bit          hit;
            bit          in_range;
            r        = '0;
            r.command = CMD_NONE;
            fi       = int'(fl);
            t        = 0;
            hit      = 1'b0;
            in_range = (fi >= 1) && (fi <= served());
            case (f)
                FUNC_CALL: begin
                    if (in_range) begin
                        if (is_called(fi)) begin
                            r.already = 1'b1;
                        end else begin
                            call_map[fi-1] = 1'b1;
                            if (cmode == CAR_IDLE)
                                r.command = head_for(fi);
                        end
                    end
                end
                FUNC_ARRIVE: begin
                    if (cmode == CAR_MOVING && in_range) begin
                        car_floor = fl;
                        if (car_floor == goal_floor) begin
                            clear_call(int'(car_floor));
                            r.command = CMD_STOP;
                        end else begin
                            r.command = CMD_MOVE;
                        end
                    end
                end
                FUNC_DONE: begin
                    if (cmode == CAR_MOVING) begin
                        cmode = CAR_IDLE;
                        if (is_called(int'(car_floor))) begin
                            hit = 1'b1;
                            t   = int'(car_floor);
                        end else begin
                            // look ahead first, then behind
                            hit = scan_calls(heading == DIR_UP, t);
                            if (!hit)
                                hit = scan_calls(heading != DIR_UP, t);
                        end
                        if (hit)
                            r.command = head_for(t);
                        else
                            r.none = 1'b1;
                    end
                end
                default: ;
            endcase
            r.dir       = heading;
            r.floor_now = car_floor;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [FLOOR_W-1:0] want,
                                    logic [FLOOR_W-1:0] got);
            if (got !== want) begin
                $error("%s expected %0d actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_car_result got);
            t_car_result want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: command %0d floor_now %0d", got.command, got.floor_now);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("command", FLOOR_W'(want.command), FLOOR_W'(got.command));
            compare_field("direction", FLOOR_W'(want.dir), FLOOR_W'(got.dir));
            compare_field("already_called", FLOOR_W'(want.already), FLOOR_W'(got.already));
            compare_field("no_pending", FLOOR_W'(want.none), FLOOR_W'(got.none));
            compare_field("floor_now", want.floor_now, got.floor_now);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [FUNC_W-1:0]  i_func;
    logic [FLOOR_W-1:0] i_floor;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [CMD_W-1:0]   o_command;
    logic               o_direction;
    logic               o_already_called;
    logic               o_no_pending;
    logic [FLOOR_W-1:0] o_floor_now;

    call_scoreboard calls_sb = new();
    int events_sent = 0;
    int stall_mode  = 0;
    int stall_run   = 0;

    elevator_call_controller i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_floor          (i_floor),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_command        (o_command),
        .o_direction      (o_direction),
        .o_already_called (o_already_called),
        .o_no_pending     (o_no_pending),
        .o_floor_now      (o_floor_now)
    );

    always #5 i_clk = ~i_clk;

    // receiver: stretches of free flow, light, heavy and solid stall
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = int'($urandom_range(0, 3));
            stall_run  = (stall_mode == 3) ? int'($urandom_range(1, 30))
                                           : int'($urandom_range(10, 120));
        end else begin
            stall_run--;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall == 1'b0)
            calls_sb.check_result(t_car_result'({o_command, o_direction, o_already_called,
                                                 o_no_pending, o_floor_now}));
    end

    task automatic send_event(input logic [FUNC_W-1:0] f, input logic [FLOOR_W-1:0] fl);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_func     = f;
        i_floor    = fl;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        calls_sb.note_event(f, fl);
        events_sent++;
    endtask

    task automatic pause_sender(input int n);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (calls_sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_floors(input logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        calls_sb.floors_cfg = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // mostly plausible trips toward the goal, with some noise on top
    task automatic pick_event(output logic [FUNC_W-1:0] f, output logic [FLOOR_W-1:0] fl);
        int roll;
        int n;
        int nxt;
        roll = int'($urandom_range(0, 99));
        n    = calls_sb.served();
        f    = FUNC_CALL;
        fl   = FLOOR_W'($urandom_range(1, n));
        if (roll < 12) begin
            f  = FUNC_W'($urandom_range(0, 3));
            fl = FLOOR_W'($urandom_range(0, 31));
        end else if (calls_sb.cmode == CAR_IDLE) begin
            f = FUNC_CALL;
        end else if (calls_sb.car_floor == calls_sb.goal_floor) begin
            if (roll < 80) begin
                f  = FUNC_DONE;
                fl = FLOOR_W'($urandom_range(0, 31));
            end
        end else if (roll < 80) begin
            nxt = (calls_sb.car_floor < calls_sb.goal_floor) ? int'(calls_sb.car_floor) + 1
                                                            : int'(calls_sb.car_floor) - 1;
            if (nxt > n)
                nxt = n;
            f  = FUNC_ARRIVE;
            fl = FLOOR_W'(nxt);
        end else if (roll >= 92) begin
            f  = FUNC_DONE;
            fl = FLOOR_W'($urandom_range(0, 31));
        end
    endtask

    task automatic run_directed();
        send_event(FUNC_CALL, 5'd0);        // floor zero ignored
        send_event(FUNC_CALL, 5'd10);       // above served floors
        send_event(FUNC_ARRIVE, 5'd3);      // arrival while idle
        send_event(FUNC_DONE, 5'd0);        // done while idle
        send_event(FUNC_UNUSED, 5'd31);
        send_event(FUNC_CALL, 5'd1);        // call at current floor stops at once
        send_event(FUNC_DONE, 5'd0);        // nothing left
        send_event(FUNC_CALL, 5'd9);
        send_event(FUNC_CALL, 5'd9);        // repeated call
        send_event(FUNC_CALL, 5'd4);        // call while travelling
        send_event(FUNC_ARRIVE, 5'd0);
        send_event(FUNC_ARRIVE, 5'd12);
        send_event(FUNC_ARRIVE, 5'd4);
        send_event(FUNC_ARRIVE, 5'd9);
        send_event(FUNC_DONE, 5'd31);       // nothing ahead, take the call behind
        send_event(FUNC_ARRIVE, 5'd4);
        send_event(FUNC_DONE, 5'd0);
        drain_results();
        write_floors(5'd16);
        send_event(FUNC_CALL, 5'd16);
        send_event(FUNC_CALL, 5'd31);
        send_event(FUNC_CALL, 5'd2);
        send_event(FUNC_ARRIVE, 5'd16);
        send_event(FUNC_DONE, 5'd0);
        drain_results();
        // car above the served floors must still find the call below
        write_floors(5'd2);
        send_event(FUNC_DONE, 5'd0);
        send_event(FUNC_ARRIVE, 5'd2);
        send_event(FUNC_DONE, 5'd0);
    endtask

    initial begin
        logic [FUNC_W-1:0]  f;
        logic [FLOOR_W-1:0] fl;
        logic [CFG_W-1:0]   cfg;
        int                 burst_left;
        int                 phase;
        int                 k;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = CFG_RESET;
        i_in_valid = 1'b0;
        i_func     = FUNC_CALL;
        i_floor    = '0;
        burst_left = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                case (phase)
                    1: cfg = 5'd16;
                    2: cfg = 5'd31;
                    NUM_PHASES - 1: cfg = CFG_RESET;
                    default: cfg = CFG_W'($urandom_range(2, 16));
                endcase
                drain_results();
                write_floors(cfg);
            end
            for (k = 0; k < PHASE_EVENTS; k++) begin
                if (k == PHASE_EVENTS / 2 && phase == 3)
                    drain_results();
                if (burst_left == 0) begin
                    pause_sender(int'($urandom_range(1, 12)));
                    burst_left = int'($urandom_range(1, 20));
                end
                pick_event(f, fl);
                send_event(f, fl);
                burst_left--;
            end
        end

        drain_results();
        $display("%0d events sent, %0d results checked", events_sent, calls_sb.checked);
        $display("served floors 2, 16, 31, 9 and random sizes; calls, trips, stops, noise");
        if (calls_sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", calls_sb.expected_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
